@@ rtl/core/slic_pkg.sv @@
// ----------------------------------------------------------------------------
// slic_pkg
// Shared types and constants of the sorted list intersection counter.
// ----------------------------------------------------------------------------
package slic_pkg;

	// fixed field widths
	localparam int COUNT_W = 11;
	localparam int RATIO_W = 8;
	localparam int CMD_W   = 2;

	localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd64;

	// command codes
	localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

	// list select in the storage address
	localparam logic LIST_A = 1'b0;
	localparam logic LIST_B = 1'b1;

	typedef struct packed {
		logic en;
		logic sel;
	} wr_ctrl_t;

	typedef struct packed {
		logic valid;
		logic hit;
	} cell_flags_t;

endpackage

@@ rtl/core/sorted_list_intersection_count.sv @@
// ----------------------------------------------------------------------------
// sorted_list_intersection_count
// Counts the values common to two sorted lists of vertex ids, by merge or
// by binary search through a chain of search cells.
// ----------------------------------------------------------------------------
// usage
//   command channel (cmd_valid / cmd_stall): each beat carries command and
//   vertex_id. append to list A or list B takes one beat per cycle and is
//   never stalled while the block is idle; an append to a full list is
//   dropped and remembered as overflow. unused command code is swallowed.
//   compute starts a count and stalls the command channel until done.
//   result channel (res_valid / res_stall): one beat per compute with
//   match_count, used_search and overflowed; both lists are then empty.
//   merge path: one merge step per cycle, using one read port per list.
//   search path: one key of the shorter list enters the cell chain per
//   cycle, and the result follows once every key has left the chain.
//   a stalled result is held in the output register; appends continue, a
//   further compute waits until the result has been taken.
//   reset: both lengths zero, overflow clear, merge_ratio 64; list contents
//   are not cleared, nothing reads them before they are written.
//   merge_ratio is written by cfg_wr_en / cfg_wr_data; the user must write
//   it only while idle, the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sorted_list_intersection_count
	import slic_pkg::*;
#(
	parameter int ID_WIDTH     = 32,
	parameter int MAX_LIST_LEN = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [RATIO_W-1:0]  cfg_wr_data,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic [CMD_W-1:0]    command,
	input  logic [ID_WIDTH-1:0] vertex_id,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [COUNT_W-1:0]  match_count,
	output logic                used_search,
	output logic                overflowed
);

	localparam int IW     = $clog2(MAX_LIST_LEN);
	localparam int CW     = $clog2(MAX_LIST_LEN + 1);
	// one cell per possible halving step of the longer list
	localparam int LEVELS = CW;
	localparam int PROD_W = CW + RATIO_W;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_MERGE  = 3'b010,
		ST_SEARCH = 3'b100
	} state_t;

	state_t              state_q;
	logic [RATIO_W-1:0]  merge_ratio_q;
	logic [CW-1:0]       len_a_q;
	logic [CW-1:0]       len_b_q;
	logic                ovf_q;

	// merge pointers, search feed and in-flight count
	logic [CW-1:0]       i_q;
	logic [CW-1:0]       j_q;
	logic [CW-1:0]       feed_q;
	logic                feed_v_s1;
	logic [CW-1:0]       pend_q;
	logic [COUNT_W-1:0]  hits_q;

	// output register
	logic                res_valid_q;
	logic [COUNT_W-1:0]  match_count_q;
	logic                used_search_q;
	logic                overflowed_q;

	logic                cmd_beat;
	logic                res_beat;
	logic                busy;
	logic                is_a;
	logic                is_b;
	logic                a_full;
	logic                b_full;
	wr_ctrl_t            wr_ctrl;
	logic [IW-1:0]       wr_idx;

	logic                swap;
	logic [CW-1:0]       long_len;
	logic [CW-1:0]       short_len;
	logic [PROD_W-1:0]   ratio_prod;
	logic                pick_merge;

	logic [IW-1:0]       a_addr;
	logic [IW-1:0]       b_addr;
	logic [ID_WIDTH-1:0] a_rd;
	logic [ID_WIDTH-1:0] b_rd;

	logic                m_go;
	logic                a_lt;
	logic                a_gt;
	logic                m_hit;
	logic [CW-1:0]       i_n;
	logic [CW-1:0]       j_n;

	logic                feed_go;
	logic                srch_done;
	logic                exit_v;
	logic                exit_hit;

	cell_flags_t         chn_flags [0:LEVELS];
	logic [ID_WIDTH-1:0] chn_key   [0:LEVELS];
	logic [CW-1:0]       chn_lo    [0:LEVELS];
	logic [CW-1:0]       chn_lim   [0:LEVELS];

	// handshakes
	assign cmd_beat  = cmd_valid & ~cmd_stall;
	assign res_beat  = res_valid_q & ~res_stall;
	assign busy      = (state_q != ST_IDLE);
	// a compute needs the output register free by the next edge
	assign cmd_stall = busy | (res_valid_q & res_stall & (command == CMD_COMPUTE));

	// appends
	assign is_a   = (command == CMD_APPEND_A);
	assign is_b   = (command == CMD_APPEND_B);
	assign a_full = (len_a_q == CW'(MAX_LIST_LEN));
	assign b_full = (len_b_q == CW'(MAX_LIST_LEN));

	assign wr_ctrl.en  = cmd_beat & ((is_a & ~a_full) | (is_b & ~b_full));
	assign wr_ctrl.sel = is_b ? LIST_B : LIST_A;
	assign wr_idx      = is_b ? len_b_q[IW-1:0] : len_a_q[IW-1:0];

	// method choice; equal lengths keep B as the shorter list
	assign swap       = (len_a_q < len_b_q);
	assign long_len   = swap ? len_b_q : len_a_q;
	assign short_len  = swap ? len_a_q : len_b_q;
	assign ratio_prod = PROD_W'(merge_ratio_q) * PROD_W'(len_b_q);
	assign pick_merge = (PROD_W'(len_a_q) < ratio_prod);

	// merge step, data for A[i] and B[j] is already registered
	assign m_go  = (i_q < len_a_q) & (j_q < len_b_q);
	assign a_lt  = (a_rd < b_rd);
	assign a_gt  = (a_rd > b_rd);
	assign m_hit = m_go & ~a_lt & ~a_gt;
	assign i_n   = i_q + CW'(m_go & ~a_gt);
	assign j_n   = j_q + CW'(m_go & ~a_lt);

	// search feed and drain
	assign feed_go   = (feed_q < short_len);
	assign exit_v    = chn_flags[LEVELS].valid;
	assign exit_hit  = chn_flags[LEVELS].valid & chn_flags[LEVELS].hit;
	assign srch_done = ~feed_go & ~feed_v_s1 & (pend_q == '0);

	// read addresses: next merge pointers, or the feed index of both lists
	always_comb begin
		unique case (state_q)
			ST_MERGE: begin
				a_addr = i_n[IW-1:0];
				b_addr = j_n[IW-1:0];
			end
			ST_SEARCH: begin
				a_addr = feed_q[IW-1:0];
				b_addr = feed_q[IW-1:0];
			end
			default: begin
				a_addr = '0;
				b_addr = '0;
			end
		endcase
	end

	slic_store #(
		.ID_WIDTH     (ID_WIDTH),
		.MAX_LIST_LEN (MAX_LIST_LEN)
	) u_store (
		.clk     (clk),
		.wr_ctrl (wr_ctrl),
		.wr_idx  (wr_idx),
		.wr_data (vertex_id),
		.a_addr  (a_addr),
		.b_addr  (b_addr),
		.a_rd    (a_rd),
		.b_rd    (b_rd)
	);

	// head of the chain: a key of the shorter list over the whole longer list
	assign chn_flags[0] = '{valid: feed_v_s1, hit: 1'b0};
	assign chn_key[0]   = swap ? a_rd : b_rd;
	assign chn_lo[0]    = '0;
	assign chn_lim[0]   = long_len;

	for (genvar g = 0; g < LEVELS; g++) begin : g_cell
		slic_cell #(
			.ID_WIDTH     (ID_WIDTH),
			.MAX_LIST_LEN (MAX_LIST_LEN)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_ctrl   (wr_ctrl),
			.wr_idx    (wr_idx),
			.wr_data   (vertex_id),
			.long_sel  (swap),
			.flags_in  (chn_flags[g]),
			.key_in    (chn_key[g]),
			.lo_in     (chn_lo[g]),
			.lim_in    (chn_lim[g]),
			.flags_out (chn_flags[g+1]),
			.key_out   (chn_key[g+1]),
			.lo_out    (chn_lo[g+1]),
			.lim_out   (chn_lim[g+1])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			merge_ratio_q <= RATIO_RESET;
			len_a_q       <= '0;
			len_b_q       <= '0;
			ovf_q         <= 1'b0;
			i_q           <= '0;
			j_q           <= '0;
			feed_q        <= '0;
			feed_v_s1     <= 1'b0;
			pend_q        <= '0;
			hits_q        <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				merge_ratio_q <= cfg_wr_data;
			end
			if (res_beat) begin
				res_valid_q <= 1'b0;
			end
			// a key is read out of the store in every feeding cycle
			feed_v_s1 <= (state_q == ST_SEARCH) && feed_go;

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_beat) begin
						unique case (command)
							CMD_APPEND_A: begin
								if (a_full) begin
									ovf_q <= 1'b1;
								end else begin
									len_a_q <= len_a_q + CW'(1);
								end
							end
							CMD_APPEND_B: begin
								if (b_full) begin
									ovf_q <= 1'b1;
								end else begin
									len_b_q <= len_b_q + CW'(1);
								end
							end
							CMD_COMPUTE: begin
								i_q     <= '0;
								j_q     <= '0;
								feed_q  <= '0;
								pend_q  <= '0;
								hits_q  <= '0;
								state_q <= pick_merge ? ST_MERGE : ST_SEARCH;
							end
							default: begin
							end
						endcase
					end
				end
				ST_MERGE: begin
					if (m_go) begin
						i_q    <= i_n;
						j_q    <= j_n;
						hits_q <= hits_q + COUNT_W'(m_hit);
					end else begin
						res_valid_q <= 1'b1;
						len_a_q     <= '0;
						len_b_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_SEARCH: begin
					if (feed_go) begin
						feed_q <= feed_q + CW'(1);
					end
					case ({feed_v_s1, exit_v})
						2'b10:   pend_q <= pend_q + CW'(1);
						2'b01:   pend_q <= pend_q - CW'(1);
						default: pend_q <= pend_q;
					endcase
					hits_q <= hits_q + COUNT_W'(exit_hit);
					if (srch_done) begin
						res_valid_q <= 1'b1;
						len_a_q     <= '0;
						len_b_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, loaded when the count finishes
	always_ff @(posedge clk) begin
		if ((state_q == ST_MERGE && !m_go) || (state_q == ST_SEARCH && srch_done)) begin
			match_count_q <= hits_q;
			used_search_q <= (state_q == ST_SEARCH);
			overflowed_q  <= ovf_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign match_count = match_count_q;
	assign used_search = used_search_q;
	assign overflowed  = overflowed_q;

endmodule

@@ rtl/core/slic_store.sv @@
// ----------------------------------------------------------------------------
// slic_store
// List A and list B storage, one write port and one registered read each.
// ----------------------------------------------------------------------------
module slic_store
	import slic_pkg::*;
#(
	parameter  int ID_WIDTH     = 32,
	parameter  int MAX_LIST_LEN = 1024,
	localparam int IW           = $clog2(MAX_LIST_LEN)
) (
	input  logic                clk,
	input  wr_ctrl_t            wr_ctrl,
	input  logic [IW-1:0]       wr_idx,
	input  logic [ID_WIDTH-1:0] wr_data,
	input  logic [IW-1:0]       a_addr,
	input  logic [IW-1:0]       b_addr,
	output logic [ID_WIDTH-1:0] a_rd,
	output logic [ID_WIDTH-1:0] b_rd
);

	logic [ID_WIDTH-1:0] mem_a [0:MAX_LIST_LEN-1];
	logic [ID_WIDTH-1:0] mem_b [0:MAX_LIST_LEN-1];
	logic [ID_WIDTH-1:0] a_rd_q;
	logic [ID_WIDTH-1:0] b_rd_q;

	always_ff @(posedge clk) begin
		if (wr_ctrl.en && wr_ctrl.sel == LIST_A) begin
			mem_a[wr_idx] <= wr_data;
		end
		a_rd_q <= mem_a[a_addr];
	end

	always_ff @(posedge clk) begin
		if (wr_ctrl.en && wr_ctrl.sel == LIST_B) begin
			mem_b[wr_idx] <= wr_data;
		end
		b_rd_q <= mem_b[b_addr];
	end

	assign a_rd = a_rd_q;
	assign b_rd = b_rd_q;

endmodule

@@ rtl/core/slic_cell.sv @@
// ----------------------------------------------------------------------------
// slic_cell
// One binary search step: probes its own copy of both lists, narrows the
// range of the key it holds and hands the key on to the next cell.
// ----------------------------------------------------------------------------
module slic_cell
	import slic_pkg::*;
#(
	parameter  int ID_WIDTH     = 32,
	parameter  int MAX_LIST_LEN = 1024,
	localparam int IW           = $clog2(MAX_LIST_LEN),
	localparam int CW           = $clog2(MAX_LIST_LEN + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wr_ctrl_t            wr_ctrl,
	input  logic [IW-1:0]       wr_idx,
	input  logic [ID_WIDTH-1:0] wr_data,
	input  logic                long_sel,
	input  cell_flags_t         flags_in,
	input  logic [ID_WIDTH-1:0] key_in,
	input  logic [CW-1:0]       lo_in,
	input  logic [CW-1:0]       lim_in,
	output cell_flags_t         flags_out,
	output logic [ID_WIDTH-1:0] key_out,
	output logic [CW-1:0]       lo_out,
	output logic [CW-1:0]       lim_out
);

	localparam int MEM_DEPTH = 2 ** (IW + 1);

	logic [ID_WIDTH-1:0] mem [0:MEM_DEPTH-1];
	logic [ID_WIDTH-1:0] rd_q;

	logic [CW-1:0]       span;
	logic [CW-1:0]       mid;
	logic                search_on;

	cell_flags_t         flags_s1;
	logic                on_s1;
	logic [ID_WIDTH-1:0] key_s1;
	logic [CW-1:0]       lo_s1;
	logic [CW-1:0]       lim_s1;
	logic [CW-1:0]       mid_s1;

	logic                hit_n;
	logic [CW-1:0]       lo_n;
	logic [CW-1:0]       lim_n;

	cell_flags_t         flags_s2;
	logic [ID_WIDTH-1:0] key_s2;
	logic [CW-1:0]       lo_s2;
	logic [CW-1:0]       lim_s2;

	// range is [lo, lim), empty range ends the search
	assign search_on = flags_in.valid & ~flags_in.hit & (lo_in < lim_in);
	assign span      = lim_in - lo_in - CW'(1);
	assign mid       = lo_in + (span >> 1);

	always_ff @(posedge clk) begin
		if (wr_ctrl.en) begin
			mem[{wr_ctrl.sel, wr_idx}] <= wr_data;
		end
		rd_q <= mem[{long_sel, mid[IW-1:0]}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
			on_s1    <= 1'b0;
			flags_s2 <= '0;
		end else begin
			flags_s1 <= flags_in;
			on_s1    <= search_on;
			flags_s2 <= '{valid: flags_s1.valid, hit: hit_n};
		end
	end

	always_ff @(posedge clk) begin
		key_s1 <= key_in;
		lo_s1  <= lo_in;
		lim_s1 <= lim_in;
		mid_s1 <= mid;
		key_s2 <= key_s1;
		lo_s2  <= lo_n;
		lim_s2 <= lim_n;
	end

	always_comb begin
		hit_n = flags_s1.hit;
		lo_n  = lo_s1;
		lim_n = lim_s1;
		if (on_s1) begin
			if (key_s1 == rd_q) begin
				hit_n = 1'b1;
			end else if (key_s1 < rd_q) begin
				lim_n = mid_s1;
			end else begin
				lo_n = mid_s1 + CW'(1);
			end
		end
	end

	assign flags_out = flags_s2;
	assign key_out   = key_s2;
	assign lo_out    = lo_s2;
	assign lim_out   = lim_s2;

endmodule

@@ rtl/core/slic_checker.sv @@
// ----------------------------------------------------------------------------
// slic_checker
// Port level checks of the intersection counter, bound to the top level.
// ----------------------------------------------------------------------------
module slic_checker
	import slic_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input logic [CMD_W-1:0]   command,
	input logic               res_valid,
	input logic               res_stall,
	input logic [COUNT_W-1:0] match_count,
	input logic               used_search,
	input logic               overflowed
);

	logic compute_beat;

	assign compute_beat = cmd_valid && !cmd_stall && (command == CMD_COMPUTE);

	// a stalled result beat stays put
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(match_count) &&
			$stable(used_search) && $stable(overflowed))
		else $error("result beat changed while stalled");

	// a count in progress blocks the command channel
	a_busy_after_compute: assert property (@(posedge clk) disable iff (!arst_n)
		compute_beat |=> cmd_stall)
		else $error("command channel open during a count");

	// the output register is free once a compute is taken
	a_free_after_compute: assert property (@(posedge clk) disable iff (!arst_n)
		compute_beat |=> !res_valid)
		else $error("result pending right after a compute beat");

	// a new result only comes out of a running count
	a_result_from_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result appeared without a count in progress");

endmodule

bind sorted_list_intersection_count slic_checker u_slic_checker (.*);

@@ test/sorted_list_intersection_count_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_intersection_count_test
// Self-checking bench for the intersection counter: appends and compute
// beats go in through the command channel under random idling and stalls,
// a scoreboard keeps its own copy of both lists and of merge_ratio and
// predicts count, method and overflow of every compute, and each result
// beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_list_intersection_count_test;
	import slic_pkg::*;

	localparam int ID_W          = 32;
	localparam int LIST_CAP      = 1024;
	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 11;
	// longest search chain plus some margin, used before config writes
	localparam int SETTLE_CYCLES = 2 * $clog2(LIST_CAP + 1) + 8;
	localparam int DRAIN_CYCLES  = 2 * SETTLE_CYCLES;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_BEATS   = 16;
	localparam int REPORT_MAX    = 10;

	// the one command code the package leaves unnamed
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// shapes of a generated list pair
	localparam int SET_SORTED = 0;
	localparam int SET_DENSE  = 1;
	localparam int SET_NOISE  = 2;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               search;
		logic               ovf;
	} tally_t;

	// keeps both lists as the block should hold them and predicts each count
	class intersect_board;
		logic [ID_W-1:0]    held_a[$];
		logic [ID_W-1:0]    held_b[$];
		logic               dropped;
		logic [RATIO_W-1:0] ratio;
		tally_t             tally_due[$];
		int                 mismatches;

		function new();
			dropped    = 1'b0;
			ratio      = RATIO_RESET;
			mismatches = 0;
		endfunction

		function void note_beat(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
			tally_t          t;
			int              i, j, k, lo, hi, mid, hits, llen, slen;
			bit              a_longer;
			logic [ID_W-1:0] key, probe;
			case (cmd)
			CMD_APPEND_A: begin
				if (held_a.size() < LIST_CAP)
					held_a.push_back(id);
				else
					dropped = 1'b1;
			end
			CMD_APPEND_B: begin
				if (held_b.size() < LIST_CAP)
					held_b.push_back(id);
				else
					dropped = 1'b1;
			end
			CMD_COMPUTE: begin
				hits     = 0;
				t.search = !(held_a.size() < int'(ratio) * held_b.size());
				if (!t.search) begin
					// two-pointer walk, both advance on a hit
					i = 0;
					j = 0;
					while (i < held_a.size() && j < held_b.size()) begin
						if (held_a[i] < held_b[j])
							i++;
						else if (held_a[i] > held_b[j])
							j++;
						else begin
							i++;
							j++;
							hits++;
						end
					end
				end else begin
					// equal lengths: b counts as the shorter one
					a_longer = !(held_a.size() < held_b.size());
					llen     = a_longer ? held_a.size() : held_b.size();
					slen     = a_longer ? held_b.size() : held_a.size();
					for (k = 0; k < slen; k++) begin
						key = a_longer ? held_b[k] : held_a[k];
						lo  = 0;
						hi  = llen - 1;
						while (hi >= lo) begin
							mid   = lo + (hi - lo) / 2;
							probe = a_longer ? held_a[mid] : held_b[mid];
							if (key == probe) begin
								hits++;
								break;
							end else if (key < probe)
								hi = mid - 1;
							else
								lo = mid + 1;
						end
					end
				end
				t.count = COUNT_W'(hits);
				t.ovf   = dropped;
				tally_due.push_back(t);
				held_a.delete();
				held_b.delete();
				dropped = 1'b0;
			end
			default: ;
			endcase
		endfunction

		function void check_tally(input logic [COUNT_W-1:0] cnt, input logic srch,
			input logic ovf);
			tally_t want;
			if (tally_due.size() == 0) begin
				if (mismatches < REPORT_MAX)
					$display("%0t: unexpected result: count %0d search %0b ovf %0b",
						$realtime, cnt, srch, ovf);
				mismatches++;
				return;
			end
			want = tally_due.pop_front();
			if (want.count !== cnt || want.search !== srch || want.ovf !== ovf) begin
				if (mismatches < REPORT_MAX)
					$display("%0t: exp/got count %0d/%0d search %0b/%0b ovf %0b/%0b",
						$realtime, want.count, cnt, want.search, srch, want.ovf, ovf);
				mismatches++;
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [RATIO_W-1:0]  cfg_wr_data;
	logic                cmd_valid;
	logic                cmd_stall;
	logic [CMD_W-1:0]    command;
	logic [ID_W-1:0]     vertex_id;
	logic                res_valid;
	logic                res_stall;
	logic [COUNT_W-1:0]  match_count;
	logic                used_search;
	logic                overflowed;

	intersect_board board;
	bit             no_idle;     // both sides busy every cycle while set
	bit             hold_go;     // asks the result side for its long hold-off
	int             beats_sent;  // accepted appends and computes

	sorted_list_intersection_count #(
		.ID_WIDTH     (ID_W),
		.MAX_LIST_LEN (LIST_CAP)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.command     (command),
		.vertex_id   (vertex_id),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.match_count (match_count),
		.used_search (used_search),
		.overflowed  (overflowed)
	);

	always #HALF_PERIOD clk = ~clk;

	// one command beat: random idle cycles first, then hold until accepted
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
		while (!no_idle && $urandom_range(0, 99) < 36) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= cmd;
		vertex_id <= id;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		board.note_beat(cmd, id);
		if (cmd != CMD_UNUSED)
			beats_sent++;
	endtask

	// new merge_ratio, written only once every result is out and the block has settled
	task automatic set_ratio(input logic [RATIO_W-1:0] r);
		cmd_valid <= 1'b0;
		while (board.tally_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.ratio = r;
	endtask

	// builds a list pair, interleaves the appends and optionally closes with compute
	task automatic send_set(input int na, input int nb, input int shape, input bit with_compute);
		logic [ID_W-1:0] qa[$];
		logic [ID_W-1:0] qb[$];
		longint unsigned v;
		int unsigned     stride;
		bit              take_a, take_b;
		if (shape == SET_NOISE) begin
			// unsorted full-width values
			repeat (na) qa.push_back($urandom);
			repeat (nb) qb.push_back($urandom);
		end else begin
			// one increasing stream split over a, b or both
			if (shape == SET_DENSE) begin
				stride = 3;
				v      = $urandom_range(0, 40);
			end else begin
				stride = $urandom_range(0, 1) ? 16 : 32'h0100_0000;
				v      = $urandom >> $urandom_range(0, 31);
			end
			while ((qa.size() < na || qb.size() < nb) && v <= 64'hFFFF_FFFF) begin
				take_a = qa.size() < na && $urandom_range(0, 2) != 0;
				take_b = qb.size() < nb && $urandom_range(0, 2) != 0;
				if (take_a)
					qa.push_back(v[ID_W-1:0]);
				if (take_b)
					qb.push_back(v[ID_W-1:0]);
				v += 1 + $urandom_range(0, stride - 1);
			end
		end
		while (qa.size() != 0 || qb.size() != 0) begin
			// stray unused code now and then
			if ($urandom_range(0, 29) == 0)
				send_beat(CMD_UNUSED, $urandom);
			if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1)))
				send_beat(CMD_APPEND_A, qa.pop_front());
			else
				send_beat(CMD_APPEND_B, qb.pop_front());
		end
		if (with_compute)
			send_beat(CMD_COMPUTE, $urandom);
	endtask

	// random sets for one ratio setting, flushed by a compute at the end
	task automatic run_random(input int quota);
		int stop, na, nb, shape, pick;
		stop = beats_sent + quota;
		while (beats_sent < stop) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				na = $urandom_range(0, 10);
				nb = $urandom_range(0, 10);
			end else if (pick < 8) begin
				// lengths right around the method boundary
				nb = $urandom_range(0, board.ratio > 60 ? 1 : 3);
				na = int'(board.ratio) * nb + $urandom_range(0, 2) - 1;
				if (na < 0)
					na = 0;
			end else if (pick == 8) begin
				na = $urandom_range(11, 40);
				nb = $urandom_range(11, 40);
			end else begin
				na = $urandom_range(0, 4);
				nb = $urandom_range(0, 30);
			end
			pick  = $urandom_range(0, 9);
			shape = pick < 6 ? SET_SORTED : (pick < 8 ? SET_DENSE : SET_NOISE);
			// a missing compute lets the next set pile onto these lists
			send_set(na, nb, shape, $urandom_range(0, 11) != 0);
		end
		send_beat(CMD_COMPUTE, $urandom);
	endtask

	// result side: check accepted beats, then pick the next stall
	initial begin : result_sink
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && !res_stall)
				board.check_tally(match_count, used_search, overflowed);
			if (hold_go && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			// long hold-off so a second compute backs up the command channel
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else if (no_idle)
				res_stall <= 1'b0;
			else
				res_stall <= ($urandom_range(0, 99) < 36);
		end
	end

	initial begin : stimulus
		int i;
		board       = new();
		no_idle     = 1'b0;
		hold_go     = 1'b0;
		beats_sent  = 0;
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= RATIO_RESET;
		cmd_valid   <= 1'b0;
		command     <= CMD_APPEND_A;
		vertex_id   <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset ratio: both lists empty
		send_beat(CMD_COMPUTE, '1);
		// single zero on each side, merge hit
		send_beat(CMD_APPEND_A, '0);
		send_beat(CMD_APPEND_B, '0);
		send_beat(CMD_COMPUTE, '0);
		// id extremes
		send_beat(CMD_APPEND_A, '0);
		send_beat(CMD_APPEND_A, '1);
		send_beat(CMD_APPEND_B, '1);
		send_beat(CMD_UNUSED, '1);
		send_beat(CMD_COMPUTE, $urandom);

		// ratio 1: key below every entry runs the search off the bottom
		set_ratio(8'd1);
		send_beat(CMD_APPEND_A, 32'd5);
		send_beat(CMD_APPEND_A, 32'd9);
		send_beat(CMD_APPEND_B, 32'd1);
		send_beat(CMD_COMPUTE, $urandom);
		// equal-ish lengths, one hit and one key past the top
		send_beat(CMD_APPEND_A, 32'd10);
		send_beat(CMD_APPEND_A, 32'd20);
		send_beat(CMD_APPEND_A, 32'd30);
		send_beat(CMD_APPEND_B, 32'd20);
		send_beat(CMD_APPEND_B, 32'd35);
		send_beat(CMD_COMPUTE, $urandom);
		// empty a against one entry in b
		send_beat(CMD_APPEND_B, 32'd7);
		send_beat(CMD_COMPUTE, $urandom);

		// ratio 0 never merges, a is the shorter list here
		set_ratio(8'd0);
		send_beat(CMD_APPEND_A, 32'd3);
		send_beat(CMD_APPEND_B, 32'd3);
		send_beat(CMD_APPEND_B, 32'd4);
		send_beat(CMD_COMPUTE, $urandom);

		// ratio 255, repeated values through the merge
		set_ratio(8'd255);
		repeat (3) send_beat(CMD_APPEND_A, 32'd5);
		repeat (2) send_beat(CMD_APPEND_B, 32'd5);
		send_beat(CMD_COMPUTE, $urandom);

		// random phases, one per ratio setting
		hold_go = 1'b1;
		run_random(PHASE_BEATS);
		set_ratio(8'd1);
		run_random(PHASE_BEATS);
		set_ratio(8'd0);
		no_idle = 1'b1;
		run_random(PHASE_BEATS);
		no_idle = 1'b0;
		set_ratio(8'd2);
		run_random(PHASE_BEATS);
		set_ratio(8'd64);
		run_random(PHASE_BEATS);
		set_ratio(8'($urandom_range(3, 254)));
		run_random(PHASE_BEATS);

		// full list a with one dropped append, searched with 16 keys
		set_ratio(8'd64);
		for (i = 0; i <= LIST_CAP; i++)
			send_beat(CMD_APPEND_A, ID_W'(2 * i));
		for (i = 0; i < 16; i++)
			send_beat(CMD_APPEND_B, ID_W'(130 * i + $urandom_range(0, 1)));
		send_beat(CMD_COMPUTE, $urandom);

		// drain and let anything stray show up
		cmd_valid <= 1'b0;
		while (board.tally_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// hard stop for a hung run
	initial begin : watchdog
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
